[rtl/crank_missing_tooth_decoder_defines.svh]
// ----------------------------------------------------------------------------
// Crank decoder assertion macros
// Concurrent check macros on clk and rst_n, empty when synthesizing.
// ----------------------------------------------------------------------------
`ifndef CRANK_MISSING_TOOTH_DECODER_DEFINES_SVH
`define CRANK_MISSING_TOOTH_DECODER_DEFINES_SVH

`ifndef SYNTHESIS
`define CMTD_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");
`define CMTD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");
`else
`define CMTD_ASSERT_IMPLIES(label, ante, cons)
`define CMTD_ASSERT_NEXT(label, ante, cons)
`endif

`endif

[rtl/cmtd_pkg.sv]
// ----------------------------------------------------------------------------
// cmtd_pkg
// Widths, register indexes, constants and types of the crank decoder.
// ----------------------------------------------------------------------------
package cmtd_pkg;

    localparam int TICK_W   = 16;
    localparam int CLK_W    = 27;
    localparam int TEETH_W  = 8;
    localparam int ANGLE_W  = 16;
    localparam int RPM_W    = 32;
    localparam int NUM_W    = 33;
    localparam int DEN_W    = 24;
    localparam int ITER_W   = 6;
    localparam int PITCH_W  = 15;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_TIMER_CLOCK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TEETH       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_ANGLE  = 2'd2;

    localparam logic [CLK_W-1:0]   TIMER_CLOCK_RST = 27'd1000000;
    localparam logic [TEETH_W-1:0] TEETH_RST       = 8'd36;
    localparam logic [ANGLE_W-1:0] SYNC_ANGLE_RST  = 16'd17280;

    // 360 deg in 1/64 deg, left aligned in the dividend
    localparam logic [NUM_W-1:0]  PITCH_NUMER = NUM_W'(23040) << (NUM_W - PITCH_W);
    localparam logic [ITER_W-1:0] PITCH_ITERS = ITER_W'(PITCH_W);
    localparam logic [ITER_W-1:0] RPM_ITERS   = ITER_W'(NUM_W);
    localparam logic [NUM_W-1:0]  RPM_SCALE   = NUM_W'(60);
    localparam logic [ANGLE_W:0]  ANGLE_WRAP  = 17'd46080;
    localparam logic [RPM_W-1:0]  RPM_SAT     = '1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_PITCH_GO,
        S_PITCH_WAIT,
        S_RPM_GO,
        S_RPM_WAIT,
        S_FINISH
    } cmtd_state_t;

    typedef struct packed {
        logic              start;
        logic [NUM_W-1:0]  numer;
        logic [DEN_W-1:0]  denom;
        logic [ITER_W-1:0] iters;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [NUM_W-1:0] quotient;
    } div_rsp_t;

endpackage

[rtl/cmtd_div.sv]
// ----------------------------------------------------------------------------
// cmtd_div
// Restoring divider, one quotient bit per cycle, left aligned dividend.
// ----------------------------------------------------------------------------
module cmtd_div
    import cmtd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic              busy_reg;
    logic              done_reg;
    logic [ITER_W-1:0] cnt_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [NUM_W-1:0]  quo_reg;
    logic [DEN_W+1:0]  diff;

    assign diff = {1'b0, rem_reg, quo_reg[NUM_W-1]} - {2'b00, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.iters;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == ITER_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            den_reg <= req.denom;
            quo_reg <= req.numer;
        end
        else if (busy_reg)
        begin
            if (!diff[DEN_W+1])
            begin
                rem_reg <= diff[DEN_W-1:0];
                quo_reg <= {quo_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[DEN_W-2:0], quo_reg[NUM_W-1]};
                quo_reg <= {quo_reg[NUM_W-2:0], 1'b0};
            end
        end
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

[rtl/crank_missing_tooth_decoder.sv]
// ----------------------------------------------------------------------------
// crank_missing_tooth_decoder
// Missing tooth crank decoder: tooth interval, sync, rpm, angle, tooth count.
// A word goes MUL, pitch division, rpm division, FINISH; a zero interval skips the rpm
// division, a stored-only word goes to FINISH. The shared divider (15 + 33 bit steps)
// serves one word at a time; IDLE takes a new one while the last result still waits.
// Reset: async active low; state clears, registers take their default values.
// ----------------------------------------------------------------------------
`include "crank_missing_tooth_decoder_defines.svh"

module crank_missing_tooth_decoder
    import cmtd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CLK_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [TICK_W-1:0]    capture_tick,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 event_valid,
    output logic                 synced,
    output logic [RPM_W-1:0]     rpm,
    output logic [ANGLE_W-1:0]   angle_q6,
    output logic [TICK_W-1:0]    tooth_count,
    output logic [TICK_W-1:0]    delta_ticks
);

    cmtd_state_t state_reg, state_next;

    logic [CLK_W-1:0]   timer_clock_reg;
    logic [TEETH_W-1:0] teeth_reg;
    logic [ANGLE_W-1:0] sync_angle_reg;

    logic [TICK_W-1:0]  prev_tick_reg;
    logic [TICK_W-1:0]  prev_delta_reg;
    logic               sync_flag_reg;
    logic [TICK_W-1:0]  teeth_seen_reg;
    logic [ANGLE_W-1:0] angle_acc_reg;
    logic [RPM_W-1:0]   rpm_held_reg;

    logic [TICK_W-1:0]  dt_reg;
    logic               skip_reg;
    logic               sync_hit_reg;
    logic [NUM_W-1:0]   num_reg;
    logic [DEN_W-1:0]   den_reg;
    logic [PITCH_W-1:0] pitch_reg;
    logic [NUM_W-1:0]   quo_reg;

    logic               out_valid_reg;
    logic               ev_reg;
    logic               synced_reg;
    logic [RPM_W-1:0]   rpm_reg;
    logic [ANGLE_W-1:0] angle_reg;
    logic [TICK_W-1:0]  tooth_reg;
    logic [TICK_W-1:0]  delta_reg;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic               in_take;
    logic               out_free;
    logic [TICK_W-1:0]  dt_now;
    logic [TICK_W+1:0]  dt_x2;
    logic [TICK_W+1:0]  pd_x3;
    logic [TEETH_W-1:0] teeth_eff;
    logic               sync_new;
    logic [ANGLE_W-1:0] angle_base;
    logic [TICK_W-1:0]  teeth_base;
    logic [ANGLE_W:0]   angle_sum;
    logic [ANGLE_W:0]   angle_wrapped;
    logic [RPM_W-1:0]   rpm_new;

    cmtd_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign in_take   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign dt_now    = capture_tick - prev_tick_reg;
    assign dt_x2     = {1'b0, dt_now, 1'b0};
    assign pd_x3     = (TICK_W+2)'(prev_delta_reg) * (TICK_W+2)'(3);
    assign teeth_eff = (teeth_reg == '0) ? TEETH_W'(1) : teeth_reg;

    // end-of-word update
    assign sync_new      = sync_flag_reg || sync_hit_reg;
    assign angle_base    = sync_hit_reg ? sync_angle_reg : angle_acc_reg;
    assign teeth_base    = sync_hit_reg ? '0 : teeth_seen_reg;
    assign angle_sum     = {1'b0, angle_base} + (ANGLE_W+1)'(pitch_reg);
    assign angle_wrapped = (angle_sum >= ANGLE_WRAP) ? (angle_sum - ANGLE_WRAP) : angle_sum;
    assign rpm_new       = quo_reg[NUM_W-1] ? RPM_SAT : quo_reg[RPM_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                    state_next = (prev_tick_reg == '0) ? S_FINISH : S_MUL;
            end
            S_MUL:        state_next = S_PITCH_GO;
            S_PITCH_GO:   state_next = S_PITCH_WAIT;
            S_PITCH_WAIT:
            begin
                if (div_rsp.done)
                    state_next = (dt_reg == '0) ? S_FINISH : S_RPM_GO;
            end
            S_RPM_GO:     state_next = S_RPM_WAIT;
            S_RPM_WAIT:
            begin
                if (div_rsp.done)
                    state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:      state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall      = 1'b1;
        div_req.start = 1'b0;
        div_req.numer = PITCH_NUMER;
        div_req.denom = DEN_W'(teeth_eff);
        div_req.iters = PITCH_ITERS;
        case (state_reg)
            S_IDLE:     in_stall = 1'b0;
            S_PITCH_GO: div_req.start = 1'b1;
            S_RPM_GO:
            begin
                div_req.start = 1'b1;
                div_req.numer = num_reg;
                div_req.denom = den_reg;
                div_req.iters = RPM_ITERS;
            end
            default:    in_stall = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timer_clock_reg <= TIMER_CLOCK_RST;
            teeth_reg       <= TEETH_RST;
            sync_angle_reg  <= SYNC_ANGLE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TIMER_CLOCK: timer_clock_reg <= cfg_data;
                REG_TEETH:       teeth_reg       <= cfg_data[TEETH_W-1:0];
                REG_SYNC_ANGLE:  sync_angle_reg  <= cfg_data[ANGLE_W-1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_tick_reg  <= '0;
            prev_delta_reg <= '0;
            sync_flag_reg  <= 1'b0;
            teeth_seen_reg <= '0;
            angle_acc_reg  <= '0;
            rpm_held_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_take)
                prev_tick_reg <= capture_tick;
            if (!out_stall)
                out_valid_reg <= 1'b0;
            if (state_reg == S_FINISH && out_free)
            begin
                out_valid_reg <= 1'b1;
                if (!skip_reg)
                begin
                    prev_delta_reg <= dt_reg;
                    sync_flag_reg  <= sync_new;
                    if (dt_reg != '0)
                        rpm_held_reg <= rpm_new;
                    if (sync_new)
                    begin
                        angle_acc_reg  <= angle_wrapped[ANGLE_W-1:0];
                        teeth_seen_reg <= teeth_base + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            dt_reg       <= dt_now;
            skip_reg     <= (prev_tick_reg == '0);
            sync_hit_reg <= !sync_flag_reg && (prev_delta_reg != '0) && (dt_x2 > pd_x3);
        end
        if (state_reg == S_MUL)
        begin
            num_reg <= NUM_W'(timer_clock_reg) * RPM_SCALE;
            den_reg <= DEN_W'(dt_reg) * DEN_W'(teeth_eff);
        end
        if (state_reg == S_PITCH_WAIT && div_rsp.done)
            pitch_reg <= div_rsp.quotient[PITCH_W-1:0];
        if (state_reg == S_RPM_WAIT && div_rsp.done)
            quo_reg <= div_rsp.quotient;
        if (state_reg == S_FINISH && out_free)
        begin
            ev_reg <= !skip_reg;
            if (skip_reg)
            begin
                synced_reg <= sync_flag_reg;
                rpm_reg    <= rpm_held_reg;
                angle_reg  <= angle_acc_reg;
                tooth_reg  <= teeth_seen_reg;
                delta_reg  <= '0;
            end
            else
            begin
                synced_reg <= sync_new;
                rpm_reg    <= (dt_reg != '0) ? rpm_new : rpm_held_reg;
                angle_reg  <= sync_new ? angle_wrapped[ANGLE_W-1:0] : angle_acc_reg;
                tooth_reg  <= sync_new ? teeth_base + 1'b1 : teeth_seen_reg;
                delta_reg  <= dt_reg;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign event_valid = ev_reg;
    assign synced      = synced_reg;
    assign rpm         = rpm_reg;
    assign angle_q6    = angle_reg;
    assign tooth_count = tooth_reg;
    assign delta_ticks = delta_reg;

    `CMTD_ASSERT_NEXT(a_sync_sticky, sync_flag_reg, sync_flag_reg)
    `CMTD_ASSERT_IMPLIES(a_div_owner, div_rsp.busy, (state_reg == S_PITCH_WAIT || state_reg == S_RPM_WAIT))
    `CMTD_ASSERT_NEXT(a_one_word, in_valid && !in_stall, in_stall)

endmodule

[bench/tb_crank_missing_tooth_decoder.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_crank_missing_tooth_decoder
// Self-checking bench for the missing tooth crank decoder. Capture words go
// in from a queue with random gaps, and result words are taken with random
// stalls. Each taken result is checked against an in-bench decoder model.
// Stimulus is a directed pass at reset settings but a randomly picked sync
// angle, then phases of wheel runs, noise and corner captures, with a
// register rewrite whenever the block is idle between phases.
// ----------------------------------------------------------------------------
module tb_crank_missing_tooth_decoder;
    import cmtd_pkg::*;

    localparam int PHASES          = 9;
    localparam int WORDS_PER_PHASE = 140;
    localparam logic [31:0] PITCH_SPAN = 32'd23040;
    localparam logic [31:0] CYCLE_SPAN = 32'd46080;

    typedef struct packed {
        logic               event_valid;
        logic               synced;
        logic [RPM_W-1:0]   rpm;
        logic [ANGLE_W-1:0] angle_q6;
        logic [TICK_W-1:0]  tooth_count;
        logic [TICK_W-1:0]  delta_ticks;
    } crank_event_t;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index    = '0;
    logic [CLK_W-1:0]     cfg_data     = '0;
    logic                 in_valid     = 1'b0;
    logic [TICK_W-1:0]    capture_tick = '0;
    logic                 out_stall    = 1'b0;
    logic                 in_stall;
    logic                 out_valid;
    logic                 event_valid;
    logic                 synced;
    logic [RPM_W-1:0]     rpm;
    logic [ANGLE_W-1:0]   angle_q6;
    logic [TICK_W-1:0]    tooth_count;
    logic [TICK_W-1:0]    delta_ticks;

    // decoder model: registers and state
    logic [CLK_W-1:0]   cf_clock      = TIMER_CLOCK_RST;
    logic [TEETH_W-1:0] cf_teeth      = TEETH_RST;
    logic [ANGLE_W-1:0] cf_sync_angle = SYNC_ANGLE_RST;
    logic [TICK_W-1:0]  m_prev_tick   = '0;
    logic [TICK_W-1:0]  m_prev_delta  = '0;
    logic               m_synced      = 1'b0;
    logic [TICK_W-1:0]  m_teeth_seen  = '0;
    logic [ANGLE_W-1:0] m_angle       = '0;
    logic [RPM_W-1:0]   m_rpm         = '0;

    logic [TICK_W-1:0] tick_queue[$];
    crank_event_t      pending_events[$];
    logic [TICK_W-1:0] g_tick = '0;
    bit                calm = 1'b0;
    int                fail_count = 0;
    int                gap_left = 0;
    int                stall_left = 0;
    bit                drv_busy;
    crank_event_t      want;

    crank_missing_tooth_decoder dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .capture_tick (capture_tick),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .event_valid  (event_valid),
        .synced       (synced),
        .rpm          (rpm),
        .angle_q6     (angle_q6),
        .tooth_count  (tooth_count),
        .delta_ticks  (delta_ticks)
    );

    always #6 clk = ~clk;

    function automatic crank_event_t decode_edge(input logic [TICK_W-1:0] tick);
        crank_event_t      ev;
        logic [TICK_W-1:0] dt;
        logic [63:0]       num;
        logic [63:0]       den;
        logic [63:0]       quo;
        logic [31:0]       pitch;
        logic [31:0]       sum;
        logic [8:0]        teeth;
        dt = '0;
        ev.event_valid = 1'b0;
        if (m_prev_tick != '0)
        begin
            teeth = (cf_teeth == '0) ? 9'd1 : {1'b0, cf_teeth};
            ev.event_valid = 1'b1;
            dt = tick - m_prev_tick;
            if (!m_synced && m_prev_delta != '0
                && (32'(dt) << 1) > 32'(m_prev_delta) * 32'd3)
            begin
                m_synced     = 1'b1;
                m_teeth_seen = '0;
                m_angle      = cf_sync_angle;
            end
            if (dt != '0)
            begin
                num   = 64'(cf_clock) * 64'd60;
                den   = 64'(dt) * 64'(teeth);
                quo   = num / den;
                m_rpm = (quo > 64'hFFFF_FFFF) ? '1 : quo[31:0];
            end
            m_prev_delta = dt;
            if (m_synced)
            begin
                pitch = PITCH_SPAN / 32'(teeth);
                sum   = 32'(m_angle) + pitch;
                if (sum >= CYCLE_SPAN)
                    sum = sum - CYCLE_SPAN;
                m_angle      = sum[ANGLE_W-1:0];
                m_teeth_seen = m_teeth_seen + 1'b1;
            end
        end
        m_prev_tick    = tick;
        ev.synced      = m_synced;
        ev.rpm         = m_rpm;
        ev.angle_q6    = m_angle;
        ev.tooth_count = m_teeth_seen;
        ev.delta_ticks = dt;
        return ev;
    endfunction

    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 20);
        return $urandom_range(40, 200);
    endfunction

    function automatic int draw_stall();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 65)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 16);
        return $urandom_range(40, 200);
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
        if (exp_v !== got_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, got_v);
            fail_count++;
        end
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left = 0;
        end
        else
        begin
            drv_busy = in_valid;
            if (in_valid && !in_stall)
            begin
                pending_events.push_back(decode_edge(capture_tick));
                drv_busy = 1'b0;
                gap_left = draw_gap();
            end
            if (!drv_busy)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (tick_queue.size() > 0)
                begin
                    capture_tick <= tick_queue.pop_front();
                    drv_busy = 1'b1;
                end
            end
            in_valid <= drv_busy;
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_events.size() == 0)
                begin
                    $error("result word with no capture pending");
                    fail_count++;
                end
                else
                begin
                    want = pending_events.pop_front();
                    check_field("event_valid", 32'(want.event_valid), 32'(event_valid));
                    check_field("synced", 32'(want.synced), 32'(synced));
                    check_field("rpm", want.rpm, rpm);
                    check_field("angle_q6", 32'(want.angle_q6), 32'(angle_q6));
                    check_field("tooth_count", 32'(want.tooth_count), 32'(tooth_count));
                    check_field("delta_ticks", 32'(want.delta_ticks), 32'(delta_ticks));
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
                stall_left = draw_stall();
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CLK_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_TIMER_CLOCK: cf_clock = val;
            REG_TEETH:       cf_teeth = val[TEETH_W-1:0];
            REG_SYNC_ANGLE:  cf_sync_angle = val[ANGLE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic end_writes();
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (tick_queue.size() != 0 || in_valid || pending_events.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic push_tick(input logic [TICK_W-1:0] t);
        tick_queue.push_back(t);
        g_tick = t;
    endtask

    task automatic push_step(input int unsigned interval);
        push_tick(g_tick + TICK_W'(interval));
    endtask

    // wheel runs with a missing tooth gap, plus noise and corner captures
    task automatic queue_edges(input int n);
        int cnt;
        int r;
        int positions;
        int per;
        int len;
        int pos;
        cnt = 0;
        while (cnt < n)
        begin
            r = $urandom_range(0, 99);
            if (r < 72)
            begin
                positions = (cf_teeth < 3) ? $urandom_range(3, 60) : int'(cf_teeth);
                per = ($urandom_range(0, 9) == 0) ? $urandom_range(400, 20000)
                                                  : $urandom_range(1, 400);
                len = $urandom_range(10, 60);
                pos = $urandom_range(0, positions - 2);
                for (int k = 0; k < len; k++)
                begin
                    if (pos >= positions - 2)
                    begin
                        push_step(per * $urandom_range(2, 3));
                        pos = 0;
                    end
                    else
                    begin
                        push_step(per + $urandom_range(0, per / 8));
                        pos++;
                    end
                end
                cnt += len;
            end
            else if (r < 90)
            begin
                len = $urandom_range(1, 6);
                for (int k = 0; k < len; k++)
                    push_tick(TICK_W'($urandom));
                cnt += len;
            end
            else
            begin
                case ($urandom_range(0, 4))
                    0: push_tick('0);
                    1: push_step(0);
                    2: push_step(1);
                    3: push_step(65535);
                    default: push_step($urandom_range(1, 8));
                endcase
                cnt++;
            end
        end
    endtask

    initial
    begin
        logic [CLK_W-1:0]   clk_v;
        logic [TEETH_W-1:0] teeth_v;
        logic [ANGLE_W-1:0] angle_v;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // sync happens only once, so the angle it loads is picked here
        case ($urandom_range(0, 4))
            0: ;
            1:
            begin
                write_reg(REG_SYNC_ANGLE, 27'd0);
                end_writes();
            end
            2:
            begin
                write_reg(REG_SYNC_ANGLE, 27'd46079);
                end_writes();
            end
            3:
            begin
                write_reg(REG_SYNC_ANGLE, 27'd65535);
                end_writes();
            end
            default:
            begin
                write_reg(REG_SYNC_ANGLE, CLK_W'($urandom_range(0, 65535)));
                end_writes();
            end
        endcase

        @(negedge clk);
        // first word stored only, zero intervals, sync threshold edges, zero
        // captures, timer wrap, widest and narrowest intervals
        push_tick(16'd100);
        push_tick(16'd1100);
        push_tick(16'd2100);
        push_tick(16'd2100);
        push_tick(16'd3100);
        push_tick(16'd4100);
        push_tick(16'd5600);
        push_tick(16'd7850);
        push_tick(16'd9100);
        push_tick(16'd10100);
        push_tick(16'd11601);
        push_tick(16'd12601);
        push_tick(16'd0);
        push_tick(16'd65535);
        push_tick(16'd0);
        push_tick(16'd1);
        push_tick(16'd1001);
        push_tick(16'd65000);
        push_tick(16'd500);
        push_tick(16'd499);
        push_tick(16'd500);
        push_tick(16'd32768);
        push_tick(16'd32768);
        queue_edges(WORDS_PER_PHASE);
        wait_drained();

        for (int p = 1; p < PHASES; p++)
        begin
            case (p)
                1:
                begin
                    clk_v   = 27'd100000000;
                    teeth_v = 8'd0;
                    angle_v = 16'd46079;
                end
                2:
                begin
                    clk_v   = 27'd1;
                    teeth_v = 8'd255;
                    angle_v = 16'd0;
                end
                3:
                begin
                    clk_v   = '1;
                    teeth_v = 8'd1;
                    angle_v = 16'hFFFF;
                end
                default:
                begin
                    case ($urandom_range(0, 5))
                        0: clk_v = CLK_W'($urandom);
                        1: clk_v = '0;
                        2: clk_v = 27'd4000000;
                        default: clk_v = CLK_W'($urandom_range(1, 100000000));
                    endcase
                    case ($urandom_range(0, 4))
                        0: teeth_v = 8'd36;
                        1: teeth_v = 8'd60;
                        2: teeth_v = 8'd12;
                        default: teeth_v = TEETH_W'($urandom_range(0, 255));
                    endcase
                    angle_v = ANGLE_W'($urandom);
                end
            endcase
            calm = ($urandom_range(0, 3) == 0);
            write_reg(REG_TIMER_CLOCK, clk_v);
            write_reg(REG_TEETH, CLK_W'(teeth_v));
            write_reg(REG_SYNC_ANGLE, CLK_W'(angle_v));
            end_writes();
            @(negedge clk);
            queue_edges(WORDS_PER_PHASE);
            wait_drained();
        end

        repeat (60) @(posedge clk);
        if (fail_count == 0 && pending_events.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #40_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

[crank_missing_tooth_decoder.f]
+incdir+rtl
rtl/cmtd_pkg.sv
rtl/cmtd_div.sv
rtl/crank_missing_tooth_decoder.sv
bench/tb_crank_missing_tooth_decoder.sv
